[src/dcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dcr_pkg;

  localparam int TIME_W       = 17;
  localparam int COLOR_W      = 8;
  localparam int SKY_KEYS_N   = 13;
  localparam int LIGHT_KEYS_N = 11;
  localparam int KEY_IDX_W    = 4;
  localparam int NUM_W        = TIME_W + COLOR_W;
  localparam int QUOT_W       = COLOR_W;
  localparam int QUOT_CNT_W   = $clog2(QUOT_W);
  localparam int CH_W         = 2;

  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [COLOR_W-1:0]   color_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef logic [CH_W-1:0]      ch_t;

  localparam time_t DAY_TIME_RESET   = 17'd4500;
  localparam time_t DAY_LENGTH_RESET = 17'd72000;

  localparam ch_t CH_RED   = 2'd0;
  localparam ch_t CH_GREEN = 2'd1;
  localparam ch_t CH_BLUE  = 2'd2;
  localparam ch_t CH_LIGHT = 2'd3;

  typedef struct packed {
    logic     hit;
    key_idx_t idx;
  } seg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    time_t            span;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  localparam time_t SKY_TIME [SKY_KEYS_N] = '{
    17'd0, 17'd3000, 17'd4000, 17'd4500, 17'd5500, 17'd7200, 17'd18000,
    17'd49500, 17'd54000, 17'd56000, 17'd57600, 17'd60000, 17'd72000
  };

  localparam color_t SKY_RED [SKY_KEYS_N] = '{
    8'd10, 8'd8, 8'd30, 8'd90, 8'd135, 8'd135, 8'd135,
    8'd135, 8'd255, 8'd120, 8'd20, 8'd10, 8'd10
  };

  localparam color_t SKY_GREEN [SKY_KEYS_N] = '{
    8'd10, 8'd8, 8'd15, 8'd40, 8'd100, 8'd206, 8'd206,
    8'd206, 8'd140, 8'd60, 8'd20, 8'd10, 8'd10
  };

  localparam color_t SKY_BLUE [SKY_KEYS_N] = '{
    8'd30, 8'd25, 8'd40, 8'd20, 8'd180, 8'd235, 8'd235,
    8'd235, 8'd50, 8'd80, 8'd50, 8'd30, 8'd30
  };

  localparam time_t LIGHT_TIME [LIGHT_KEYS_N] = '{
    17'd0, 17'd3600, 17'd4500, 17'd6000, 17'd7200, 17'd49500,
    17'd54000, 17'd56000, 17'd57600, 17'd60000, 17'd72000
  };

  localparam color_t LIGHT_LVL [LIGHT_KEYS_N] = '{
    8'd30, 8'd20, 8'd60, 8'd180, 8'd255, 8'd255,
    8'd200, 8'd80, 8'd35, 8'd30, 8'd30
  };

endpackage

`default_nettype wire

[src/day_cycle_keyframe_color_ramp.sv]
`timescale 1ns / 1ps
`default_nettype none

// Time-of-day color ramp. Each accepted request optionally advances the day
// counter by one tick (wrapping to zero at cfg_day_length), then returns the
// time together with the sky color and light level interpolated between
// keyframes, with each value rounded down. After the request is accepted, the
// segment search result is registered, then the four channels are worked one
// after another through a single multiplier stage and one shared 8-step
// restoring divider, and the result is registered once out_stall lets it go.
// A new request is taken as soon as the previous result is registered, even
// while that result still waits on out_stall. The configuration port is
// always ready.

module day_cycle_keyframe_color_ramp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_advance,
  output logic                    out_valid,
  input  logic                    out_stall,
  output dcr_pkg::time_t          out_time_now,
  output dcr_pkg::color_t         out_sky_red,
  output dcr_pkg::color_t         out_sky_green,
  output dcr_pkg::color_t         out_sky_blue,
  output dcr_pkg::color_t         out_light_level,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  dcr_pkg::time_t          cfg_day_length
);
  import dcr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  time_t            time_r, time_nxt;
  time_t            length_r;
  ch_t              ch_r;
  seg_t             seg_sky_r, seg_lt_r;
  seg_t             seg_sky, seg_lt;
  color_t           a_r;
  logic             fall_r;
  time_t            span_r;
  logic [NUM_W-1:0] prod_r;
  color_t           res_r [4];
  time_t            out_time_r;
  color_t           out_red_r, out_green_r, out_blue_r, out_light_r;

  logic             in_accept;
  logic             out_free;
  logic [TIME_W:0]  time_inc;
  key_idx_t         sky_nx, lt_nx;
  color_t           a_sel, b_sel, diff_sel;
  time_t            klo, khi, span_sel, dt_sel;
  logic             hit_sel, fall_sel;
  color_t           res_val;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  dcr_seg_find u_seg (
    .day_time  (time_r),
    .sky_seg   (seg_sky),
    .light_seg (seg_lt)
  );

  dcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign time_inc = {1'b0, time_r} + {{TIME_W{1'b0}}, 1'b1};

  always_comb begin
    time_nxt = time_r;
    if (in_accept && in_advance) begin
      time_nxt = (time_inc[TIME_W-1:0] >= length_r) ? '0 : time_inc[TIME_W-1:0];
    end
  end

  assign sky_nx = seg_sky_r.idx + 1'b1;
  assign lt_nx  = seg_lt_r.idx + 1'b1;

  always_comb begin
    klo     = SKY_TIME[seg_sky_r.idx];
    khi     = SKY_TIME[sky_nx];
    hit_sel = seg_sky_r.hit;
    case (ch_r)
      CH_RED: begin
        a_sel = SKY_RED[seg_sky_r.idx];
        b_sel = SKY_RED[sky_nx];
      end
      CH_GREEN: begin
        a_sel = SKY_GREEN[seg_sky_r.idx];
        b_sel = SKY_GREEN[sky_nx];
      end
      CH_BLUE: begin
        a_sel = SKY_BLUE[seg_sky_r.idx];
        b_sel = SKY_BLUE[sky_nx];
      end
      default: begin
        a_sel   = LIGHT_LVL[seg_lt_r.idx];
        b_sel   = LIGHT_LVL[lt_nx];
        klo     = LIGHT_TIME[seg_lt_r.idx];
        khi     = LIGHT_TIME[lt_nx];
        hit_sel = seg_lt_r.hit;
      end
    endcase
    fall_sel = a_sel > b_sel;
    diff_sel = fall_sel ? a_sel - b_sel : b_sel - a_sel;
    dt_sel   = time_r - klo;
    span_sel = khi - klo;
    if (!hit_sel) begin
      diff_sel = '0;
      span_sel = time_t'(1);
    end
  end

  always_comb begin
    div_req.start = (state_r == ST_LOAD);
    div_req.num   = prod_r + (fall_r ? NUM_W'(span_r - time_t'(1)) : '0);
    div_req.span  = span_r;
  end

  assign res_val = fall_r ? a_r - div_rsp.quot : a_r + div_rsp.quot;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (ch_r == CH_LIGHT) ? ST_DONE : ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      time_r      <= DAY_TIME_RESET;
      length_r    <= DAY_LENGTH_RESET;
      ch_r        <= CH_RED;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      time_r      <= time_nxt;
      if (cfg_valid && cfg_ready) begin
        length_r <= cfg_day_length;
      end
      if (state_r == ST_SEARCH) begin
        ch_r <= CH_RED;
      end else if (state_r == ST_DIV && div_rsp.done) begin
        ch_r <= ch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SEARCH) begin
      seg_sky_r <= seg_sky;
      seg_lt_r  <= seg_lt;
    end
    if (state_r == ST_MUL) begin
      a_r    <= a_sel;
      fall_r <= fall_sel;
      span_r <= span_sel;
      prod_r <= NUM_W'(diff_sel) * NUM_W'(dt_sel);
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      res_r[ch_r] <= res_val;
    end
    if (state_r == ST_DONE && out_free) begin
      out_time_r  <= time_r;
      out_red_r   <= res_r[CH_RED];
      out_green_r <= res_r[CH_GREEN];
      out_blue_r  <= res_r[CH_BLUE];
      out_light_r <= res_r[CH_LIGHT];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_time_now    = out_time_r;
  assign out_sky_red     = out_red_r;
  assign out_sky_green   = out_green_r;
  assign out_sky_blue    = out_blue_r;
  assign out_light_level = out_light_r;

endmodule

`default_nettype wire

[src/dcr_seg_find.sv]
`timescale 1ns / 1ps
`default_nettype none

module dcr_seg_find (
  input  dcr_pkg::time_t day_time,
  output dcr_pkg::seg_t  sky_seg,
  output dcr_pkg::seg_t  light_seg
);
  import dcr_pkg::*;

  always_comb begin
    sky_seg = '0;
    for (int i = 0; i < SKY_KEYS_N - 1; i++) begin
      if (day_time >= SKY_TIME[i] && day_time < SKY_TIME[i+1]) begin
        sky_seg.hit = 1'b1;
        sky_seg.idx = key_idx_t'(i);
      end
    end
  end

  always_comb begin
    light_seg = '0;
    for (int i = 0; i < LIGHT_KEYS_N - 1; i++) begin
      if (day_time >= LIGHT_TIME[i] && day_time < LIGHT_TIME[i+1]) begin
        light_seg.hit = 1'b1;
        light_seg.idx = key_idx_t'(i);
      end
    end
  end

endmodule

`default_nettype wire

[src/dcr_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module dcr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dcr_pkg::div_req_t req,
  output dcr_pkg::div_rsp_t rsp
);
  import dcr_pkg::*;

  // The quotient is known to stay below 2**QUOT_W, so only QUOT_W steps are run.
  logic                  busy_r;
  logic                  done_r;
  logic [QUOT_CNT_W-1:0] cnt_r;
  time_t                 rem_r;
  time_t                 span_r;
  logic [QUOT_W-1:0]     low_r;
  logic [QUOT_W-1:0]     quot_r;
  logic [TIME_W:0]       trial;
  logic [TIME_W:0]       diff;
  logic                  fits;

  assign trial = {rem_r, low_r[QUOT_W-1]};
  assign diff  = trial - {1'b0, span_r};
  assign fits  = trial >= {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= QUOT_CNT_W'(QUOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num[NUM_W-1:QUOT_W];
      low_r  <= req.num[QUOT_W-1:0];
      span_r <= req.span;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      low_r  <= {low_r[QUOT_W-2:0], 1'b0};
      quot_r <= {quot_r[QUOT_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire
